### design/p2a_pkg.sv
// Shared constants, layer tables and types for the pressure to altitude pipeline.
package p2a_pkg;

	localparam int OUT_FRAC_BITS = 4;

	localparam int PRES_W    = 17;
	localparam int ALT_W     = 21;
	localparam int N_W       = 24;
	localparam int MSB_W     = 5;
	localparam int MANT_W    = 32;
	localparam int FRAC_L2   = 28;
	localparam int L2_W      = 34;
	localparam int Q_W       = 28;
	localparam int SUM_W     = 30;
	localparam int RC_W      = 28;
	localparam int K_W       = 4;
	localparam int FAC_W     = 32;
	localparam int COEF_W    = 34;
	localparam int HB_W      = 17;
	localparam int H_W       = 36;
	localparam int LAYERS    = 5;
	localparam int LAYER_W   = 3;
	localparam int LOG_CELLS = 28;
	localparam int EXP_CELLS = 13;
	localparam int SH        = 16 - OUT_FRAC_BITS;

	// Register count from the input edge to the output register.
	localparam int LAT = 2 + LOG_CELLS + 3 + 2 * EXP_CELLS + 2;

	localparam logic [PRES_W-1:0] P_MAX   = 17'd101325;
	localparam logic [29:0]       LN2_Q30 = 30'd744261118;

	typedef enum logic [1:0] {
		KIND_ISO,
		KIND_DOWN,
		KIND_UP
	} kind_t;

	// Squaring log2 in Q28, evaluated only on constants.
	function automatic logic [63:0] log2_q28(input logic [63:0] n);
		int          msb;
		logic [63:0] m;
		logic [63:0] res;
		msb = 0;
		for (int i = 0; i < 32; i++) begin
			if (n[i]) msb = i;
		end
		m   = n << (31 - msb);
		res = 64'(msb) << 28;
		for (int b = 27; b >= 0; b--) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				m   = m >> 1;
				res = res | (64'd1 << b);
			end
		end
		return res;
	endfunction

	localparam logic [63:0] GM_E12 = 64'd980665 * 64'd289644;
	localparam logic [63:0] R_E8   = 64'd83144598;
	localparam logic [63:0] TWO28  = 64'd268435456;

	localparam logic [63:0] ALPHA_65 = (R_E8 * 64'd65 * 64'd10 * TWO28) / GM_E12;
	localparam logic [63:0] ALPHA_10 = (R_E8 * 64'd10 * 64'd10 * TWO28) / GM_E12;
	localparam logic [63:0] ALPHA_28 = (R_E8 * 64'd28 * 64'd10 * TWO28) / GM_E12;
	localparam logic [63:0] K_ISO_1  = (R_E8 * 64'd21665 * 64'd1000 * 64'd4096) / GM_E12;
	localparam logic [63:0] K_ISO_4  = (R_E8 * 64'd27065 * 64'd1000 * 64'd4096) / GM_E12;
	localparam logic [63:0] COEF_0   = (64'd28815 * 64'd100 * 64'd65536) / 64'd65;
	localparam logic [63:0] COEF_2   = (64'd21665 * 64'd100 * 64'd65536) / 64'd10;
	localparam logic [63:0] COEF_3   = (64'd22865 * 64'd100 * 64'd65536) / 64'd28;

	localparam logic [N_W-1:0] PB100 [LAYERS] = '{
		24'd10132500, 24'd2263210, 24'd547489, 24'd86802, 24'd11091
	};
	localparam logic [HB_W-1:0] HB [LAYERS] = '{
		17'd0, 17'd11000, 17'd20000, 17'd32000, 17'd47000
	};
	localparam kind_t KIND [LAYERS] = '{
		KIND_DOWN, KIND_ISO, KIND_UP, KIND_UP, KIND_ISO
	};
	localparam logic [FAC_W-1:0] FAC [LAYERS] = '{
		FAC_W'(ALPHA_65), FAC_W'(K_ISO_1), FAC_W'(ALPHA_10), FAC_W'(ALPHA_28), FAC_W'(K_ISO_4)
	};
	localparam logic [COEF_W-1:0] COEF [LAYERS] = '{
		COEF_W'(COEF_0), '0, COEF_W'(COEF_2), COEF_W'(COEF_3), '0
	};
	localparam logic [L2_W-1:0] LA [LAYERS] = '{
		L2_W'(log2_q28(64'd10132500)), L2_W'(log2_q28(64'd2263210)),
		L2_W'(log2_q28(64'd547489)),   L2_W'(log2_q28(64'd86802)),
		L2_W'(log2_q28(64'd11091))
	};

	// Reciprocals of the series divisors 2 through 14, scaled by 2^28.
	localparam logic [RC_W-1:0] RECIP [EXP_CELLS] = '{
		RC_W'(TWO28 / 64'd2),  RC_W'(TWO28 / 64'd3),  RC_W'(TWO28 / 64'd4),
		RC_W'(TWO28 / 64'd5),  RC_W'(TWO28 / 64'd6),  RC_W'(TWO28 / 64'd7),
		RC_W'(TWO28 / 64'd8),  RC_W'(TWO28 / 64'd9),  RC_W'(TWO28 / 64'd10),
		RC_W'(TWO28 / 64'd11), RC_W'(TWO28 / 64'd12), RC_W'(TWO28 / 64'd13),
		RC_W'(TWO28 / 64'd14)
	};

	localparam logic [63:0] ALT_SAT_FULL = 64'd90000 << OUT_FRAC_BITS;
	localparam logic [ALT_W-1:0] ALT_SAT =
		(ALT_SAT_FULL > ((64'd1 << ALT_W) - 64'd1)) ? '1 : ALT_W'(ALT_SAT_FULL);

	typedef struct packed {
		logic [MANT_W-1:0]  m;
		logic [FRAC_L2-1:0] res;
	} lg_t;

	typedef struct packed {
		logic [Q_W-1:0]   term;
		logic [Q_W-1:0]   z;
		logic [SUM_W-1:0] sum;
		logic             neg;
	} ser_t;

	typedef struct packed {
		logic [LAYER_W-1:0] layer;
		logic               zero;
		logic               over;
		logic [MSB_W-1:0]   msb;
		logic [L2_W-1:0]    dln;
	} side_t;

endpackage

### design/p2a_log2_cell.sv
// One squaring step of the log2 chain: yields one fraction bit per cycle.
module p2a_log2_cell
	import p2a_pkg::*;
(
	input  logic clk,
	input  lg_t  d,
	output lg_t  q
);

	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0]     sh;
	lg_t                 q_s1;

	assign sq = d.m * d.m;
	assign sh = sq[2*MANT_W-1:MANT_W-1];

	always_ff @(posedge clk) begin
		if (sh[MANT_W]) begin
			q_s1.m   <= sh[MANT_W:1];
			q_s1.res <= {d.res[FRAC_L2-2:0], 1'b1};
		end else begin
			q_s1.m   <= sh[MANT_W-1:0];
			q_s1.res <= {d.res[FRAC_L2-2:0], 1'b0};
		end
	end

	assign q = q_s1;

endmodule

### design/p2a_exp_cell.sv
// One term of the exponential series: multiply by z, divide by k, accumulate.
module p2a_exp_cell
	import p2a_pkg::*;
(
	input  logic            clk,
	input  ser_t            d,
	input  logic [K_W-1:0]  k,
	input  logic [RC_W-1:0] recip,
	output ser_t            q
);

	logic [2*Q_W-1:0]      prod;
	logic [Q_W+RC_W-1:0]   qp;
	logic [Q_W-1:0]        q0;
	logic [Q_W+K_W-1:0]    qk;
	logic [Q_W-1:0]        rem;
	logic [Q_W-1:0]        quo;
	logic                  sub;
	logic [Q_W-1:0]        t_s1;
	logic [Q_W-1:0]        z_s1;
	logic [SUM_W-1:0]      sum_s1;
	logic                  neg_s1;
	ser_t                  q_s2;

	assign prod = d.term * d.z;

	always_ff @(posedge clk) begin
		t_s1   <= prod[2*Q_W-1:Q_W];
		z_s1   <= d.z;
		sum_s1 <= d.sum;
		neg_s1 <= d.neg;
	end

	// The reciprocal product is low by at most one; one compare fixes it.
	assign qp  = t_s1 * recip;
	assign q0  = qp[Q_W+RC_W-1:RC_W];
	assign qk  = q0 * k;
	assign rem = t_s1 - qk[Q_W-1:0];
	assign quo = (rem >= Q_W'(k)) ? q0 + Q_W'(1) : q0;
	assign sub = neg_s1 & ~k[0];

	always_ff @(posedge clk) begin
		q_s2.term <= quo;
		q_s2.z    <= z_s1;
		q_s2.neg  <= neg_s1;
		q_s2.sum  <= sub ? sum_s1 - SUM_W'(quo) : sum_s1 + SUM_W'(quo);
	end

	assign q = q_s2;

endmodule

### design/pressure_to_altitude.sv
// Top level: pipelined barometric pressure to altitude converter.
// Throughput is one word per cycle; busy is always low and done cannot be stalled.
// Most of the pipeline is the 28-cell log2 chain and the 13 two-stage series cells.
// Reset (arst_n low) clears the valid line at once; no result is issued for words
// that were in flight. Datapath registers are not reset.
module pressure_to_altitude
	import p2a_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [PRES_W-1:0] pressure_pa,
	output logic              done,
	output logic [ALT_W-1:0]  altitude_q4,
	output logic              out_of_range
);

	// The pipeline never holds off a word, so a word can enter every cycle.
	assign busy = 1'b0;

	// Valid bit for every register stage of the datapath.
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	// Stage 1: scale the pressure to hundredths of a pascal and flag the
	// special cases of zero pressure and pressure above sea level.
	logic [N_W-1:0] n_s1;
	logic           zero_s1;
	logic           over_s1;

	always_ff @(posedge clk) begin
		n_s1    <= N_W'(pressure_pa) * N_W'(100);
		zero_s1 <= (pressure_pa == '0);
		over_s1 <= (pressure_pa > P_MAX);
	end

	// Stage 2: pick the highest layer whose base pressure is at or above the
	// input, and normalize the scaled pressure into a Q31 mantissa.
	logic [LAYER_W-1:0] layer_c;
	logic [MSB_W-1:0]   msb_c;
	logic [MANT_W-1:0]  m_s2;
	side_t              side_s2;

	always_comb begin
		priority if (PB100[4] >= n_s1) layer_c = LAYER_W'(4);
		else if (PB100[3] >= n_s1)     layer_c = LAYER_W'(3);
		else if (PB100[2] >= n_s1)     layer_c = LAYER_W'(2);
		else if (PB100[1] >= n_s1)     layer_c = LAYER_W'(1);
		else                           layer_c = LAYER_W'(0);
	end

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < N_W; i++) begin
			if (n_s1[i]) msb_c = MSB_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		m_s2          <= MANT_W'(n_s1) << (MSB_W'(MANT_W - 1) - msb_c);
		side_s2.layer <= layer_c;
		side_s2.zero  <= zero_s1;
		side_s2.over  <= over_s1;
		side_s2.msb   <= msb_c;
		side_s2.dln   <= '0;
	end

	// Log2 chain: each cell squares the mantissa and emits one fraction bit.
	lg_t   lg [LOG_CELLS+1];
	side_t lg_side_q [LOG_CELLS];

	assign lg[0] = '{m: m_s2, res: '0};

	for (genvar gi = 0; gi < LOG_CELLS; gi++) begin : g_log
		p2a_log2_cell u_cell (
			.clk (clk),
			.d   (lg[gi]),
			.q   (lg[gi+1])
		);
	end

	always_ff @(posedge clk) begin
		lg_side_q[0] <= side_s2;
		for (int i = 1; i < LOG_CELLS; i++) begin
			lg_side_q[i] <= lg_side_q[i-1];
		end
	end

	// Stage 3: log2 difference between the layer base and the input, held at
	// zero when the input sits on or above the base pressure.
	side_t           side_l;
	logic [L2_W-1:0] lb;
	logic [L2_W-1:0] la;
	logic [L2_W-1:0] dl2_s3;
	side_t           side_s3;

	assign side_l = lg_side_q[LOG_CELLS-1];
	assign lb     = L2_W'({side_l.msb, lg[LOG_CELLS].res});
	assign la     = LA[side_l.layer];

	always_ff @(posedge clk) begin
		dl2_s3  <= (la > lb) ? la - lb : '0;
		side_s3 <= side_l;
	end

	// Stage 4: convert to a natural log.
	logic [L2_W+30-1:0] dln_p;
	logic [L2_W-1:0]    dln_s4;
	side_t              side_s4;

	assign dln_p = dl2_s3 * LN2_Q30;

	always_ff @(posedge clk) begin
		dln_s4  <= dln_p[L2_W+30-1:30];
		side_s4 <= side_s3;
	end

	// Stage 5: exponent of the power form. Isothermal layers feed zero into
	// the series, which then carries no meaning for them.
	logic [FAC_W+L2_W-1:0] zp;
	kind_t                 kind_4;
	logic [Q_W-1:0]        z_s5;
	logic                  neg_s5;
	side_t                 side_s5;

	assign kind_4 = KIND[side_s4.layer];
	assign zp     = FAC[side_s4.layer] * dln_s4;

	always_ff @(posedge clk) begin
		z_s5    <= (kind_4 == KIND_ISO) ? '0 : zp[Q_W+28-1:28];
		neg_s5  <= (kind_4 == KIND_DOWN);
		side_s5 <= '{layer: side_s4.layer, zero: side_s4.zero, over: side_s4.over,
			msb: side_s4.msb, dln: dln_s4};
	end

	// Series chain: cell j adds or subtracts the term z^(j+2)/(j+2)!.
	ser_t  ser [EXP_CELLS+1];
	side_t ex_side_q [2*EXP_CELLS];

	assign ser[0] = '{term: z_s5, z: z_s5, sum: SUM_W'(z_s5), neg: neg_s5};

	for (genvar gj = 0; gj < EXP_CELLS; gj++) begin : g_exp
		p2a_exp_cell u_cell (
			.clk   (clk),
			.d     (ser[gj]),
			.k     (K_W'(gj + 2)),
			.recip (RECIP[gj]),
			.q     (ser[gj+1])
		);
	end

	always_ff @(posedge clk) begin
		ex_side_q[0] <= side_s5;
		for (int i = 1; i < 2*EXP_CELLS; i++) begin
			ex_side_q[i] <= ex_side_q[i-1];
		end
	end

	// Stage 6: scale the log or the series result by the layer factor and
	// add the base height, all in Q16 metres.
	side_t                side_e;
	kind_t                kind_e;
	logic [Q_W-1:0]       e_val;
	logic [COEF_W-1:0]    op_a;
	logic [L2_W-1:0]      op_b;
	logic [COEF_W+L2_W-1:0] hprod;
	logic [H_W-1:0]       inc;
	logic [H_W-1:0]       h16_s6;
	logic                 zero_s6;
	logic                 over_s6;

	assign side_e = ex_side_q[2*EXP_CELLS-1];
	assign kind_e = KIND[side_e.layer];
	assign e_val  = ser[EXP_CELLS].sum[SUM_W-1] ? '0 : ser[EXP_CELLS].sum[Q_W-1:0];

	always_comb begin
		unique case (kind_e)
			KIND_ISO: begin
				op_a = COEF_W'(FAC[side_e.layer]);
				op_b = side_e.dln;
			end
			default: begin
				op_a = COEF[side_e.layer];
				op_b = L2_W'(e_val);
			end
		endcase
	end

	assign hprod = op_a * op_b;
	assign inc   = (kind_e == KIND_ISO) ? hprod[H_W+24-1:24] : hprod[H_W+28-1:28];

	always_ff @(posedge clk) begin
		h16_s6  <= (H_W'(HB[side_e.layer]) << 16) + inc;
		zero_s6 <= side_e.zero;
		over_s6 <= side_e.over;
	end

	// Stage 7: round half up to the output fraction, saturate, and apply the
	// special cases.
	logic [H_W-1:0]   hr;
	logic [H_W-1:0]   hs;
	logic [ALT_W-1:0] alt_s7;
	logic             oor_s7;

	assign hr = h16_s6 + (H_W'(1) << (SH - 1));
	assign hs = hr >> SH;

	always_ff @(posedge clk) begin
		if (zero_s6) begin
			alt_s7 <= ALT_SAT;
		end else if (over_s6) begin
			alt_s7 <= '0;
		end else if (hs > H_W'(ALT_SAT)) begin
			alt_s7 <= ALT_SAT;
		end else begin
			alt_s7 <= hs[ALT_W-1:0];
		end
		oor_s7 <= zero_s6;
	end

	assign altitude_q4  = alt_s7;
	assign out_of_range = oor_s7;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted word produced no result at the pipeline latency");

	a_oor_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (altitude_q4 == ALT_SAT))
		else $error("out of range result is not saturated");

	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (altitude_q4 <= ALT_SAT))
		else $error("altitude exceeds saturation value");
`endif

endmodule
